/* sv/pmcc_pkg.sv */
// shared types and constants for the pressure matrix crosstalk compensator
`default_nettype none

package pmcc_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int SAMPLE_MAX  = 4095;
   localparam int SCALE_W     = 8;
   localparam int ROW_W       = 5;
   localparam int COLUMN_W    = 6;
   localparam int LEVEL_W     = 16;
   localparam int NUM_W       = SAMPLE_W + SCALE_W;
   localparam int DEN_W       = SAMPLE_W;
   localparam int DIV_CNT_W   = $clog2(NUM_W);
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int DEFAULT_ROWS    = 32;
   localparam int DEFAULT_COLUMNS = 64;

   localparam logic [SAMPLE_W-1:0] REF_RESET   = 12'd4095;
   localparam logic [SAMPLE_W-1:0] THR_RESET   = 12'd5;
   localparam logic [SCALE_W-1:0]  SCALE_RESET = 8'd255;
   localparam logic [LEVEL_W-1:0]  LEVEL_MAX   = 16'hFFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REF_FULL_SCALE  = 2'd0,
      CSR_NOISE_THRESHOLD = 2'd1,
      CSR_OUTPUT_SCALE    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_LOOKUP,
      BK_EVAL,
      BK_DIVIDE
   } back_state_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] ref_full_scale;
      logic [SAMPLE_W-1:0] noise_threshold;
      logic [SCALE_W-1:0]  output_scale;
   } cfg_type;

   typedef struct packed {
      logic                is_read;
      logic                in_range;
      logic [SAMPLE_W-1:0] sample;
   } cmd_type;

   typedef struct packed {
      logic               valid;
      logic [LEVEL_W-1:0] level;
      logic               saturated;
   } result_type;

endpackage

`default_nettype wire

/* sv/pressure_matrix_crosstalk_compensator_unit.sv */
// top level of the pressure matrix crosstalk compensator
//
// usage
//  - request beats (req_*) are taken on a clock edge with start high and busy
//    low; action 0 loads a sample into cell (row, column), action 1 reads the
//    compensated cell
//  - each read gives exactly one result beat: rsp_valid is high for a single
//    cycle with rsp_level / rsp_saturated; loads give no result
//  - the result side has no back-pressure, every strobe must be captured
//  - csr_* writes the reference, threshold and scale registers; csr_ready is
//    always high, unknown indexes are dropped; write only while idle
//  - a four-entry command queue sits between the request front end and the
//    executing back end, so up to four beats are taken while one runs
//  - a load passes through lookup, where its cell and column sum are written;
//    a read passes lookup, evaluate, 20 divider steps and the result register
//    before its result beat, and the back end takes no new beat meanwhile;
//    quiet reads and reads with a non-positive denominator skip the divider
//  - after reset the back end clears the sample store and the column sums,
//    one cell per cycle, ROWS*COLUMNS cells (2048 by default); busy is high
//    meanwhile, register writes are taken as usual
`default_nettype none

module pressure_matrix_crosstalk_compensator_unit
   import pmcc_pkg::*;
#(
   parameter int ROWS    = DEFAULT_ROWS,
   parameter int COLUMNS = DEFAULT_COLUMNS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_action,
   input  wire logic [ROW_W-1:0]       req_row,
   input  wire logic [COLUMN_W-1:0]    req_column,
   input  wire logic [SAMPLE_W-1:0]    req_sample,
   // result channel
   output logic                        rsp_valid,
   output logic [LEVEL_W-1:0]          rsp_level,
   output logic                        rsp_saturated,
   // register write channel
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [SAMPLE_W-1:0]    csr_data
);

   localparam int DEPTH   = ROWS * COLUMNS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int CMD_W   = $bits(cmd_type);
   localparam int QDATA_W = CMD_W + COL_W + ADDR_W;

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // front end to queue
   logic              push;
   cmd_type           front_cmd;
   logic [COL_W-1:0]  front_col;
   logic [ADDR_W-1:0] front_addr;

   // queue to back end
   logic               q_empty;
   logic               q_full;
   logic [QDATA_W-1:0] q_head;
   logic               pop;
   cmd_type            head_cmd;
   logic [COL_W-1:0]   head_col;
   logic [ADDR_W-1:0]  head_addr;

   logic       clearing;
   result_type rsp;

   // register file; the user must write it only between items, the block does not enforce this
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_REF_FULL_SCALE:  cfg_in.ref_full_scale  = csr_data;
            CSR_NOISE_THRESHOLD: cfg_in.noise_threshold = csr_data;
            CSR_OUTPUT_SCALE:    cfg_in.output_scale    = csr_data[SCALE_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ref_full_scale  <= REF_RESET;
         cfg_ff.noise_threshold <= THR_RESET;
         cfg_ff.output_scale    <= SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   // accept and classify request beats
   pmcc_front #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_front (
      .start      (start),
      .clearing   (clearing),
      .queue_full (q_full),
      .action     (req_action),
      .row        (req_row),
      .column     (req_column),
      .sample     (req_sample),
      .busy       (busy),
      .push       (push),
      .cmd        (front_cmd),
      .col_idx    (front_col),
      .addr       (front_addr)
   );

   // decoupling queue
   pmcc_queue #(
      .DATA_W (QDATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({front_cmd, front_col, front_addr}),
      .pop       (pop),
      .empty     (q_empty),
      .full      (q_full),
      .head      (q_head)
   );

   assign head_cmd  = q_head[QDATA_W-1 -: CMD_W];
   assign head_col  = q_head[ADDR_W +: COL_W];
   assign head_addr = q_head[ADDR_W-1:0];

   // memories, sums and the divide sequence
   pmcc_back #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (~q_empty),
      .head_cmd   (head_cmd),
      .head_col   (head_col),
      .head_addr  (head_addr),
      .pop        (pop),
      .clearing   (clearing),
      .rsp        (rsp)
   );

   assign rsp_valid     = rsp.valid;
   assign rsp_level     = rsp.level;
   assign rsp_saturated = rsp.saturated;

`ifndef SYNTHESIS
   // the queue is never written while it holds four beats
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("command queue written while full");

   // the clearing pass starts right after reset and holds requests off
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low right after reset");

   // no result comes out while the store is being cleared
   a_quiet_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_valid)
      else $error("result strobe during clearing pass");

   // a saturated result always carries the maximum level
   a_saturated_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_level == LEVEL_MAX)
      else $error("saturated result without maximum level");
`endif

endmodule

`default_nettype wire

/* sv/pmcc_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module pmcc_div
   import pmcc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic                  done,
   output logic [NUM_W-1:0]      quotient
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     dvs_ff, dvs_in;
   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       diff;
   logic                 fits;

   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};

      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;

      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* sv/pmcc_queue.sv */
// short show-ahead command queue between front and back
`default_nettype none

module pmcc_queue
   import pmcc_pkg::*;
#(
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output logic                   empty,
   output logic                   full,
   output logic [DATA_W-1:0]      head
);

   logic [DATA_W-1:0] entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head  = entries_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* sv/pmcc_front.sv */
// request front end: accept, range check and cell address formation
`default_nettype none

module pmcc_front
   import pmcc_pkg::*;
#(
   parameter int ROWS    = DEFAULT_ROWS,
   parameter int COLUMNS = DEFAULT_COLUMNS,
   localparam int DEPTH  = ROWS * COLUMNS,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
   input  wire logic                start,
   input  wire logic                clearing,
   input  wire logic                queue_full,
   input  wire logic                action,
   input  wire logic [ROW_W-1:0]    row,
   input  wire logic [COLUMN_W-1:0] column,
   input  wire logic [SAMPLE_W-1:0] sample,
   output logic                     busy,
   output logic                     push,
   output cmd_type                  cmd,
   output logic [COL_W-1:0]         col_idx,
   output logic [ADDR_W-1:0]        addr
);

   logic row_ok;
   logic col_ok;

   always_comb begin
      busy   = clearing | queue_full;
      push   = start & ~busy;
      row_ok = 32'(row) < ROWS;
      col_ok = 32'(column) < COLUMNS;

      cmd.is_read  = action;
      cmd.in_range = row_ok & col_ok;
      cmd.sample   = sample;

      // out-of-range values are never used downstream
      col_idx = COL_W'(column);
      addr    = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(column);
   end

endmodule

`default_nettype wire

/* sv/pmcc_back.sv */
// execution back end: sample store, column sums and compensation sequencer
`default_nettype none

module pmcc_back
   import pmcc_pkg::*;
#(
   parameter int ROWS    = DEFAULT_ROWS,
   parameter int COLUMNS = DEFAULT_COLUMNS,
   localparam int DEPTH  = ROWS * COLUMNS,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1,
   localparam int SUM_W  = $clog2(ROWS * SAMPLE_MAX + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              head_valid,
   input  wire cmd_type           head_cmd,
   input  wire logic [COL_W-1:0]  head_col,
   input  wire logic [ADDR_W-1:0] head_addr,
   output logic                   pop,
   output logic                   clearing,
   output result_type             rsp
);

   back_state_type state_ff, state_in;

   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic                cur_read_ff, cur_read_in;
   logic [SAMPLE_W-1:0] cur_sample_ff, cur_sample_in;
   logic [ADDR_W-1:0]   cur_addr_ff, cur_addr_in;
   logic [COL_W-1:0]    cur_col_ff, cur_col_in;
   logic [SAMPLE_W-1:0] smp_ff, smp_in;
   logic [SUM_W-1:0]    others_ff, others_in;
   logic                quiet_ff, quiet_in;
   result_type          rsp_ff, rsp_in;

   logic [SAMPLE_W-1:0] store_mem [DEPTH];
   logic [SUM_W-1:0]    sum_mem [COLUMNS];
   logic [SAMPLE_W-1:0] rd_sample_ff;
   logic [SUM_W-1:0]    rd_sum_ff;

   logic                store_we;
   logic [ADDR_W-1:0]   store_waddr;
   logic [SAMPLE_W-1:0] store_wdata;
   logic                sum_we;
   logic [COL_W-1:0]    sum_waddr;
   logic [SUM_W-1:0]    sum_wdata;

   logic                denom_nonpos;
   logic [DEN_W-1:0]    denom;
   logic [NUM_W-1:0]    product;
   logic                div_start;
   logic                div_done;
   logic [NUM_W-1:0]    div_quotient;

   pmcc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (denom),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      cur_read_in   = cur_read_ff;
      cur_sample_in = cur_sample_ff;
      cur_addr_in   = cur_addr_ff;
      cur_col_in    = cur_col_ff;
      smp_in        = smp_ff;
      others_in     = others_ff;
      quiet_in      = quiet_ff;
      rsp_in        = rsp_ff;
      rsp_in.valid  = 1'b0;

      pop         = 1'b0;
      clearing    = 1'b0;
      store_we    = 1'b0;
      store_waddr = cur_addr_ff;
      store_wdata = cur_sample_ff;
      sum_we      = 1'b0;
      sum_waddr   = cur_col_ff;
      sum_wdata   = rd_sum_ff - SUM_W'(rd_sample_ff) + SUM_W'(cur_sample_ff);

      denom_nonpos = others_ff >= SUM_W'(cfg.ref_full_scale);
      denom        = cfg.ref_full_scale - others_ff[DEN_W-1:0];
      product      = NUM_W'(smp_ff) * NUM_W'(cfg.output_scale);
      div_start    = 1'b0;

      unique case (state_ff)
         BK_CLEAR: begin
            clearing    = 1'b1;
            store_we    = 1'b1;
            store_waddr = clr_addr_ff;
            store_wdata = '0;
            sum_we      = 32'(clr_addr_ff) < COLUMNS;
            sum_waddr   = clr_addr_ff[COL_W-1:0];
            sum_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (head_valid) begin
               pop           = 1'b1;
               cur_read_in   = head_cmd.is_read;
               cur_sample_in = head_cmd.sample;
               cur_addr_in   = head_addr;
               cur_col_in    = head_col;
               if (head_cmd.in_range) begin
                  state_in = BK_LOOKUP;
               end else if (head_cmd.is_read) begin
                  rsp_in.valid     = 1'b1;
                  rsp_in.level     = '0;
                  rsp_in.saturated = 1'b0;
               end
            end
         end
         BK_LOOKUP: begin
            if (cur_read_ff) begin
               smp_in    = rd_sample_ff;
               others_in = (rd_sum_ff >= SUM_W'(rd_sample_ff)) ?
                           rd_sum_ff - SUM_W'(rd_sample_ff) : '0;
               quiet_in  = rd_sample_ff <= cfg.noise_threshold;
               state_in  = BK_EVAL;
            end else begin
               store_we = 1'b1;
               sum_we   = 1'b1;
               state_in = BK_IDLE;
            end
         end
         BK_EVAL: begin
            if (quiet_ff) begin
               rsp_in.valid     = 1'b1;
               rsp_in.level     = '0;
               rsp_in.saturated = 1'b0;
               state_in         = BK_IDLE;
            end else if (denom_nonpos) begin
               rsp_in.valid     = 1'b1;
               rsp_in.level     = LEVEL_MAX;
               rsp_in.saturated = 1'b1;
               state_in         = BK_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            if (div_done) begin
               rsp_in.valid = 1'b1;
               if (div_quotient[NUM_W-1:LEVEL_W] != '0) begin
                  rsp_in.level     = LEVEL_MAX;
                  rsp_in.saturated = 1'b1;
               end else begin
                  rsp_in.level     = div_quotient[LEVEL_W-1:0];
                  rsp_in.saturated = 1'b0;
               end
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_addr_ff  <= '0;
         rsp_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.level     <= rsp_in.level;
      rsp_ff.saturated <= rsp_in.saturated;
      cur_read_ff      <= cur_read_in;
      cur_sample_ff    <= cur_sample_in;
      cur_addr_ff      <= cur_addr_in;
      cur_col_ff       <= cur_col_in;
      smp_ff           <= smp_in;
      others_ff        <= others_in;
      quiet_ff         <= quiet_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= store_wdata;
      end
      rd_sample_ff <= store_mem[head_addr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_waddr] <= sum_wdata;
      end
      rd_sum_ff <= sum_mem[head_col];
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire
